[rtl/sosyn_pkg.sv]
// shared types, register codes and saturation helpers for the synapse step block
// no dependencies; imported by every module under rtl
package sosyn_pkg;

    localparam int ACC_W = 52;

    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    typedef enum logic [2:0] {
        REG_ACT_DECAY_RATE  = 3'd0,
        REG_COND_DECAY_RATE = 3'd1,
        REG_ACT_GAIN_STEP   = 3'd2,
        REG_COND_GAIN       = 3'd3,
        REG_REVERSAL        = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic        [16:0] act_decay_rate;
        logic        [16:0] cond_decay_rate;
        logic signed [31:0] act_gain_step;
        logic signed [31:0] cond_gain;
        logic signed [31:0] reversal_potential;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] activation_in;
        logic signed [31:0] membrane_voltage;
        logic               voltage_valid;
    } item_t;

    typedef struct packed {
        logic signed [31:0] conductance;
        logic signed [31:0] channel_current;
        logic signed [31:0] activation_level;
        logic               saturated;
    } result_t;

    typedef enum logic [2:0] {
        OP_A_RATE = 3'd0,
        OP_Y_RATE = 3'd1,
        OP_A_GAIN = 3'd2,
        OP_Y_GAIN = 3'd3,
        OP_DIFF_G = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_sel;
        logic    acc_a;
        logic    acc_yp;
        logic    acc_y;
        logic    acc_g;
        logic    acc_i;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic vvalid;
    } status_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } sat_t;

    function automatic sat_t sat32(input logic signed [ACC_W-1:0] x);
        sat_t r;
        if (x > SAT_MAX)
        begin
            r.val  = 32'sh7FFF_FFFF;
            r.clip = 1'b1;
        end
        else if (x < SAT_MIN)
        begin
            r.val  = 32'sh8000_0000;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = x[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sext32(input logic signed [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

endpackage

[rtl/sosyn_ctrl.sv]
// sequencer for one synapse step: orders the shared multiplier and the accumulate steps
// depends on sosyn_pkg
module sosyn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  sosyn_pkg::status_t stat,
    output sosyn_pkg::cmd_t    cmd
);
    import sosyn_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_MUL_A   = 10'b00_0000_0010,
        S_ACC_A   = 10'b00_0000_0100,
        S_ACC_YP  = 10'b00_0000_1000,
        S_ACC_Y   = 10'b00_0001_0000,
        S_MUL_G   = 10'b00_0010_0000,
        S_ACC_G   = 10'b00_0100_0000,
        S_MUL_I   = 10'b00_1000_0000,
        S_ACC_I   = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign slot_free    = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = OP_A_RATE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_sel = OP_A_RATE;
                state_next  = S_ACC_A;
            end
            S_ACC_A:
            begin
                // decay product of y issued while a_new is formed
                cmd.acc_a   = 1'b1;
                cmd.mul_sel = OP_Y_RATE;
                state_next  = S_ACC_YP;
            end
            S_ACC_YP:
            begin
                cmd.acc_yp  = 1'b1;
                cmd.mul_sel = OP_A_GAIN;
                state_next  = S_ACC_Y;
            end
            S_ACC_Y:
            begin
                cmd.acc_y  = 1'b1;
                state_next = S_MUL_G;
            end
            S_MUL_G:
            begin
                cmd.mul_sel = OP_Y_GAIN;
                state_next  = S_ACC_G;
            end
            S_ACC_G:
            begin
                cmd.acc_g  = 1'b1;
                state_next = stat.vvalid ? S_MUL_I : S_OUT;
            end
            S_MUL_I:
            begin
                cmd.mul_sel = OP_DIFF_G;
                state_next  = S_ACC_I;
            end
            S_ACC_I:
            begin
                cmd.acc_i  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // a finished step never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && result_valid_reg && !result_ready))
        else $error("result overwritten before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result_valid)
        else $error("loaded result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("second item taken while a step is running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_sel == OP_DIFF_G && state_reg == S_MUL_I) |-> stat.vvalid)
        else $error("current computed without a voltage");

endmodule

[rtl/sosyn_dp.sv]
// datapath: channel state, shared 33x33 multiplier, floor scaling, saturation, result register
// depends on sosyn_pkg; driven by sosyn_ctrl through cmd_t
module sosyn_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  sosyn_pkg::cfg_t    cfg,
    input  sosyn_pkg::item_t   item_data,
    input  sosyn_pkg::cmd_t    cmd,
    output sosyn_pkg::status_t stat,
    output sosyn_pkg::result_t result_data
);
    import sosyn_pkg::*;

    logic signed [31:0]      sum_reg, a_reg, y_reg, held_reg, g_reg, volt_reg;
    logic                    vvalid_reg, clip_reg;
    logic signed [ACC_W-1:0] partial_reg;
    logic signed [65:0]      prod_reg, prod_next;
    logic signed [32:0]      opa, opb, diff;
    logic signed [ACC_W-1:0] pf;
    result_t                 out_reg;

    sat_t sum_sat, a_sat, y_sat, g_sat, i_sat;

    assign diff = {cfg.reversal_potential[31], cfg.reversal_potential}
                - {volt_reg[31], volt_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            OP_A_RATE:
            begin
                opa = {a_reg[31], a_reg};
                opb = {16'b0, cfg.act_decay_rate};
            end
            OP_Y_RATE:
            begin
                opa = {y_reg[31], y_reg};
                opb = {16'b0, cfg.cond_decay_rate};
            end
            OP_A_GAIN:
            begin
                opa = {a_reg[31], a_reg};
                opb = {cfg.act_gain_step[31], cfg.act_gain_step};
            end
            OP_Y_GAIN:
            begin
                opa = {y_reg[31], y_reg};
                opb = {cfg.cond_gain[31], cfg.cond_gain};
            end
            OP_DIFF_G:
            begin
                opa = diff;
                opb = {g_reg[31], g_reg};
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_next = opa * opb;

    // arithmetic shift of the exact product is floor(p / 2^16)
    assign pf = {{(ACC_W-50){prod_reg[65]}}, prod_reg[65:16]};

    assign sum_sat = sat32(sext32(sum_reg) + sext32(item_data.activation_in));
    assign a_sat   = sat32(sext32(a_reg) - pf + sext32(sum_reg));
    assign y_sat   = sat32(partial_reg + pf);
    assign g_sat   = sat32(pf);
    assign i_sat   = sat32(pf);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            volt_reg   <= item_data.membrane_voltage;
            vvalid_reg <= item_data.voltage_valid;
        end
        if (cmd.acc_yp)
        begin
            partial_reg <= sext32(y_reg) - pf;
        end
        if (cmd.acc_g)
        begin
            g_reg <= g_sat.val;
        end
        if (cmd.out_load)
        begin
            out_reg.conductance      <= g_reg;
            out_reg.channel_current  <= held_reg;
            out_reg.activation_level <= a_reg;
            out_reg.saturated        <= clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            a_reg    <= '0;
            y_reg    <= '0;
            held_reg <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sum_reg  <= sum_sat.val;
                clip_reg <= sum_sat.clip;
            end
            if (cmd.acc_a)
            begin
                a_reg    <= a_sat.val;
                clip_reg <= clip_reg | a_sat.clip;
            end
            if (cmd.acc_y)
            begin
                y_reg    <= y_sat.val;
                clip_reg <= clip_reg | y_sat.clip;
            end
            if (cmd.acc_g)
            begin
                clip_reg <= clip_reg | g_sat.clip;
            end
            if (cmd.acc_i)
            begin
                held_reg <= i_sat.val;
                clip_reg <= clip_reg | i_sat.clip;
            end
        end
    end

    assign stat.vvalid = vvalid_reg;
    assign result_data = out_reg;

endmodule

[rtl/second_order_synapse_step_top.sv]
// top level of the second-order synapse step block: configuration registers and wiring
// depends on sosyn_pkg, sosyn_ctrl and sosyn_dp
//
// Each transfer on the item channel advances a dual-exponential synaptic channel by one
// forward-Euler step in signed Q16.16 and yields exactly one result. All products run
// through one shared 33x33 multiplier with a register after it. Steps are a sequence of
// multiply and accumulate states, plus a multiply for the current if voltage_valid is high;
// no new item is taken until a step ends, and a step stalls at its end while an earlier
// result waits. A finished result sits in an output register, so the next item is accepted
// while it waits. Configuration writes take effect at once and are meant for idle periods.
module second_order_synapse_step_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sosyn_pkg::item_t   item_data,
    output logic               result_valid,
    input  logic               result_ready,
    output sosyn_pkg::result_t result_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sosyn_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.act_decay_rate     <= 17'd6554;
            cfg_reg.cond_decay_rate    <= 17'd6554;
            cfg_reg.act_gain_step      <= 32'sd6554;
            cfg_reg.cond_gain          <= 32'sd65536;
            cfg_reg.reversal_potential <= 32'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACT_DECAY_RATE:  cfg_reg.act_decay_rate     <= cfg_data[16:0];
                REG_COND_DECAY_RATE: cfg_reg.cond_decay_rate    <= cfg_data[16:0];
                REG_ACT_GAIN_STEP:   cfg_reg.act_gain_step      <= cfg_data;
                REG_COND_GAIN:       cfg_reg.cond_gain          <= cfg_data;
                REG_REVERSAL:        cfg_reg.reversal_potential <= cfg_data;
                default:
                begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    sosyn_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    sosyn_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_data   (item_data),
        .cmd         (cmd),
        .stat        (stat),
        .result_data (result_data)
    );

endmodule
